@@ hdl/gbc_pkg.sv @@
// shared types and constants for the grid bucket best corner block
package gbc_pkg;

  localparam int COORD_W     = 12;
  localparam int SCORE_W     = 32;
  localparam int LVL_W       = 3;
  localparam int CELL_W      = 12;
  localparam int MAX_LEVELS  = 8;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    FUNC_MARK = 2'd0,
    FUNC_CAND = 2'd1,
    FUNC_READ = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    CFG_CELL_SIZE = 2'd0,
    CFG_GRID_COLS = 2'd1,
    CFG_GRID_ROWS = 2'd2,
    CFG_THRESHOLD = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0]         csize;
    logic [6:0]         grid_columns;
    logic [6:0]         grid_rows;
    logic [SCORE_W-1:0] score_threshold;
  } cfg_t;

  typedef struct packed {
    func_t              op;
    logic [CELL_W-1:0]  cidx;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [LVL_W-1:0]   lvl;
    logic [SCORE_W-1:0] score;
  } qent_t;

  typedef struct packed {
    logic occupied;
    logic has_best;
  } stat_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [LVL_W-1:0]   lvl;
    logic [SCORE_W-1:0] score;
  } best_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_IDX
  } front_state_t;

  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_EXEC
  } back_state_t;

endpackage

@@ hdl/gbc_div.sv @@
// restoring divider, one quotient bit per cycle
module gbc_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [gbc_pkg::COORD_W-1:0] dividend,
  input  logic [7:0]                  divisor,
  output logic                        busy,
  output logic [gbc_pkg::COORD_W-1:0] quotient
);
  import gbc_pkg::*;

  localparam int CW = $clog2(COORD_W);

  logic [CW-1:0]      cnt;
  logic [7:0]         rem;
  logic [COORD_W-1:0] quo;
  logic [8:0]         trial;
  logic [8:0]         diff;
  logic               ge;
  logic [7:0]         rem_next;

  always_comb begin
    trial    = {rem, quo[COORD_W-1]};
    diff     = trial - {1'b0, divisor};
    ge       = trial >= {1'b0, divisor};
    rem_next = ge ? diff[7:0] : trial[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CW'(COORD_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[COORD_W-2:0], ge};
    end
  end

  assign quotient = quo;

endmodule

@@ hdl/gbc_front.sv @@
// front end: accepts requests, scales and divides positions, finds the cell
module gbc_front #(
  parameter int MAX_CELLS = 4096
) (
  input  logic                        clk,
  input  logic                        rst,
  input  gbc_pkg::cfg_t               cfg,
  input  logic                        hold,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  func,
  input  logic [gbc_pkg::COORD_W-1:0] pos_x,
  input  logic [gbc_pkg::COORD_W-1:0] pos_y,
  input  logic [gbc_pkg::LVL_W-1:0]   pyr_level,
  input  logic [gbc_pkg::SCORE_W-1:0] cand_score,
  input  logic [gbc_pkg::CELL_W-1:0]  read_cell,
  input  logic                        q_full,
  output logic                        q_push,
  output gbc_pkg::qent_t              q_ent
);
  import gbc_pkg::*;

  localparam logic [3:0]  LVL_LIMIT  = 4'(MAX_LEVELS);
  localparam logic [14:0] CELL_LIMIT = 15'(MAX_CELLS);

  front_state_t       state, state_next;
  func_t              f_op;
  logic [COORD_W-1:0] f_x, f_y;
  logic [LVL_W-1:0]   f_lvl;
  logic [SCORE_W-1:0] f_score;
  logic [CELL_W-1:0]  f_rcell;

  logic               accept;
  logic [18:0]        sh_x, sh_y;
  logic               cand_ok;
  logic [COORD_W-1:0] div_x_in, div_y_in;
  logic [7:0]         cs_eff;
  logic               div_start;
  logic               busy_x, busy_y;
  logic [COORD_W-1:0] quo_x, quo_y;
  logic               is_read;
  logic [6:0]         mul_a;
  logic [13:0]        sum;
  logic               in_grid;
  logic               idx_ok;

  assign in_ready = (state == F_IDLE) && !hold;
  assign accept   = in_valid && in_ready;
  assign cs_eff   = (cfg.csize == 8'd0) ? 8'd1 : cfg.csize;

  always_comb begin
    sh_x     = {7'd0, pos_x} << pyr_level;
    sh_y     = {7'd0, pos_y} << pyr_level;
    cand_ok  = ({1'b0, pyr_level} < LVL_LIMIT) && (sh_x[18:COORD_W] == '0) &&
               (sh_y[18:COORD_W] == '0) && (cand_score > cfg.score_threshold);
    div_x_in = (func_t'(func) == FUNC_MARK) ? pos_x : sh_x[COORD_W-1:0];
    div_y_in = (func_t'(func) == FUNC_MARK) ? pos_y : sh_y[COORD_W-1:0];
  end

  gbc_div u_div_x (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_x_in),
    .divisor  (cs_eff),
    .busy     (busy_x),
    .quotient (quo_x)
  );

  gbc_div u_div_y (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_y_in),
    .divisor  (cs_eff),
    .busy     (busy_y),
    .quotient (quo_y)
  );

  // one multiplier serves both cell index and grid size for readout
  always_comb begin
    is_read = (f_op == FUNC_READ);
    mul_a   = is_read ? cfg.grid_rows : quo_y[6:0];
    sum     = ({7'd0, mul_a} * {7'd0, cfg.grid_columns}) +
              (is_read ? 14'd0 : {7'd0, quo_x[6:0]});
    in_grid = (quo_x < {5'd0, cfg.grid_columns}) && (quo_y < {5'd0, cfg.grid_rows});
    if (is_read) begin
      idx_ok = ({2'd0, f_rcell} < sum) && ({3'd0, f_rcell} < CELL_LIMIT);
    end else begin
      idx_ok = in_grid && ({1'b0, sum} < CELL_LIMIT);
    end
    q_ent.op    = f_op;
    q_ent.cidx  = is_read ? f_rcell : sum[CELL_W-1:0];
    q_ent.x     = f_x;
    q_ent.y     = f_y;
    q_ent.lvl   = f_lvl;
    q_ent.score = f_score;
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    q_push     = 1'b0;
    case (state)
      F_IDLE: begin
        if (accept) begin
          case (func_t'(func))
            FUNC_MARK: begin
              div_start  = 1'b1;
              state_next = F_DIV;
            end
            FUNC_CAND: begin
              if (cand_ok) begin
                div_start  = 1'b1;
                state_next = F_DIV;
              end
            end
            FUNC_READ: state_next = F_IDX;
            default: ;
          endcase
        end
      end
      F_DIV: begin
        if (!busy_x && !busy_y) begin
          state_next = F_IDX;
        end
      end
      F_IDX: begin
        if (!idx_ok) begin
          state_next = F_IDLE;
        end else if (!q_full) begin
          q_push     = 1'b1;
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_op    <= func_t'(func);
      f_x     <= div_x_in;
      f_y     <= div_y_in;
      f_lvl   <= pyr_level;
      f_score <= cand_score;
      f_rcell <= read_cell;
    end
  end

endmodule

@@ hdl/gbc_queue.sv @@
// short request queue between front and back
module gbc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  gbc_pkg::qent_t push_ent,
  output logic           full,
  input  logic           pop,
  output gbc_pkg::qent_t head,
  output logic           empty
);
  import gbc_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [PW-1:0] LAST = PW'(QUEUE_DEPTH - 1);

  qent_t       slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [PW:0]   count;

  assign full  = (count == (PW + 1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_ent;
    end
  end

endmodule

@@ hdl/gbc_back.sv @@
// back end: cell status and best corner memories, read-modify-write per request
module gbc_back #(
  parameter int MAX_CELLS = 4096
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [gbc_pkg::SCORE_W-1:0] threshold,
  input  logic                        q_empty,
  input  gbc_pkg::qent_t              q_head,
  output logic                        q_pop,
  output logic                        clearing,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        cell_valid,
  output logic [gbc_pkg::COORD_W-1:0] corner_x,
  output logic [gbc_pkg::COORD_W-1:0] corner_y,
  output logic [gbc_pkg::LVL_W-1:0]   corner_level,
  output logic [gbc_pkg::SCORE_W-1:0] corner_score
);
  import gbc_pkg::*;

  localparam int AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_CELLS - 1);

  stat_t stat_mem [MAX_CELLS];
  best_t best_mem [MAX_CELLS];

  back_state_t state, state_next;
  logic [AW-1:0] clr_addr;
  logic [AW-1:0] b_addr;
  logic [AW-1:0] rd_addr;
  qent_t         b_ent;
  stat_t         stat_rd;
  best_t         best_rd;

  logic          stat_we;
  logic [AW-1:0] stat_wa;
  stat_t         stat_wd;
  logic          best_we;
  best_t         best_wd;
  logic          out_free;
  logic          out_load;
  logic          beats;
  logic          rd_valid;

  assign rd_addr  = q_head.cidx[AW-1:0];
  assign clearing = (state == B_CLEAR);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    beats         = !stat_rd.has_best || (b_ent.score > best_rd.score);
    rd_valid      = stat_rd.has_best && (best_rd.score > threshold);
    best_wd.x     = b_ent.x;
    best_wd.y     = b_ent.y;
    best_wd.lvl   = b_ent.lvl;
    best_wd.score = b_ent.score;
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    stat_we    = 1'b0;
    stat_wa    = b_addr;
    stat_wd    = '0;
    best_we    = 1'b0;
    out_load   = 1'b0;
    case (state)
      B_CLEAR: begin
        stat_we = 1'b1;
        stat_wa = clr_addr;
        if (clr_addr == LAST_ADDR) begin
          state_next = B_IDLE;
        end
      end
      B_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = B_EXEC;
        end
      end
      B_EXEC: begin
        case (b_ent.op)
          FUNC_MARK: begin
            stat_we          = 1'b1;
            stat_wd.occupied = 1'b1;
            stat_wd.has_best = stat_rd.has_best;
            state_next       = B_IDLE;
          end
          FUNC_CAND: begin
            if (!stat_rd.occupied && beats) begin
              stat_we          = 1'b1;
              stat_wd.has_best = 1'b1;
              best_we          = 1'b1;
            end
            state_next = B_IDLE;
          end
          FUNC_READ: begin
            // readout waits for the output register, then clears the cell
            if (out_free) begin
              out_load   = 1'b1;
              stat_we    = 1'b1;
              state_next = B_IDLE;
            end
          end
          default: state_next = B_IDLE;
        endcase
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == B_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b_ent  <= q_head;
      b_addr <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (stat_we) begin
      stat_mem[stat_wa] <= stat_wd;
    end
    if (q_pop) begin
      stat_rd <= stat_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (best_we) begin
      best_mem[b_addr] <= best_wd;
    end
    if (q_pop) begin
      best_rd <= best_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      cell_valid   <= rd_valid;
      corner_x     <= rd_valid ? best_rd.x : '0;
      corner_y     <= rd_valid ? best_rd.y : '0;
      corner_level <= rd_valid ? best_rd.lvl : '0;
      corner_score <= rd_valid ? best_rd.score : '0;
    end
  end

  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == B_CLEAR) |-> !q_pop)
    else $error("request taken during clearing pass");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("pop from empty queue");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !cell_valid) |-> (corner_score == '0 && corner_x == '0 &&
                                    corner_y == '0 && corner_level == '0))
    else $error("invalid readout carries nonzero corner");

  a_read_waits: assert property (@(posedge clk) disable iff (rst)
    (state == B_EXEC && b_ent.op == FUNC_READ && !out_free) |=> (state == B_EXEC))
    else $error("readout left exec while output busy");

endmodule

@@ hdl/grid_bucket_best_corner_core.sv @@
// top level of the grid bucket best corner block
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  in       | in_valid / in_ready  | func, pos_x, pos_y, pyr_level, cand_score,
//           |                      | read_cell
//  out      | out_valid/out_ready  | cell_valid, corner_x, corner_y, corner_level,
//           |                      | corner_score
//  cfg      | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// mark and candidate requests pass through the front end, where two 12-step
// dividers, one per axis, map positions to cells; readout skips the dividers.
// the back end does one read-modify-write of the cell memories per request;
// a two-entry queue lets the front continue while the back waits.
// after reset a clearing pass over all MAX_CELLS cells zeroes the cell status
// memory, with in_ready low; cfg_ready is always high.
// a stalled output holds the back end on a readout; the queue then fills and
// in_ready drops.
module grid_bucket_best_corner_core #(
  parameter int MAX_CELLS = 4096
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  func,
  input  logic [gbc_pkg::COORD_W-1:0] pos_x,
  input  logic [gbc_pkg::COORD_W-1:0] pos_y,
  input  logic [gbc_pkg::LVL_W-1:0]   pyr_level,
  input  logic [gbc_pkg::SCORE_W-1:0] cand_score,
  input  logic [gbc_pkg::CELL_W-1:0]  read_cell,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        cell_valid,
  output logic [gbc_pkg::COORD_W-1:0] corner_x,
  output logic [gbc_pkg::COORD_W-1:0] corner_y,
  output logic [gbc_pkg::LVL_W-1:0]   corner_level,
  output logic [gbc_pkg::SCORE_W-1:0] corner_score,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [31:0]                 cfg_data
);
  import gbc_pkg::*;

  cfg_t  cfg;
  logic  clearing;
  logic  q_push, q_pop, q_full, q_empty;
  qent_t q_ent, q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.csize           <= 8'd30;
      cfg.grid_columns    <= 7'd22;
      cfg.grid_rows       <= 7'd16;
      cfg.score_threshold <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_CELL_SIZE: cfg.csize           <= cfg_data[7:0];
        CFG_GRID_COLS: cfg.grid_columns    <= cfg_data[6:0];
        CFG_GRID_ROWS: cfg.grid_rows       <= cfg_data[6:0];
        CFG_THRESHOLD: cfg.score_threshold <= cfg_data[SCORE_W-1:0];
        default: ;
      endcase
    end
  end

  gbc_front #(
    .MAX_CELLS (MAX_CELLS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .hold       (clearing),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .pyr_level  (pyr_level),
    .cand_score (cand_score),
    .read_cell  (read_cell),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_ent      (q_ent)
  );

  gbc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_ent (q_ent),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  gbc_back #(
    .MAX_CELLS (MAX_CELLS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .threshold    (cfg.score_threshold),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .clearing     (clearing),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .cell_valid   (cell_valid),
    .corner_x     (corner_x),
    .corner_y     (corner_y),
    .corner_level (corner_level),
    .corner_score (corner_score)
  );

endmodule
